/* rtl/core/mnlc_pkg.sv */
// shared types and constants for the midi note light controller
`timescale 1ns / 1ps

package mnlc_pkg;

  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 4;
  localparam int NOTE_W     = 7;
  localparam int LIGHTS_W   = 6;
  localparam int LIGHT_IDX_W = 3;
  localparam int NUM_LIGHT_REGS = 6;

  localparam int DEFAULT_PACKET_BYTES = 3;
  localparam int DEFAULT_LIGHT_COUNT  = 6;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_CHANNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_NOTE_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_NOTE_5   = 3'd6;

  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_OTHER    = 2'd2
  } kind_e;

  // one framed packet handed from the framer to the light logic
  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] note;
  } packet_t;

  typedef logic [NUM_LIGHT_REGS-1:0][NOTE_W-1:0] light_notes_t;

  // reset notes run 12, 13, ... upward
  function automatic logic [NOTE_W-1:0] light_note_reset(input int idx);
    return NOTE_W'(12 + idx);
  endfunction

endpackage

/* rtl/core/mnlc_framer.sv */
// front end: frames received bytes into packets and classifies the status
`timescale 1ns / 1ps

module mnlc_framer #(
  parameter int PACKET_BYTES = mnlc_pkg::DEFAULT_PACKET_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mnlc_pkg::CHAN_W-1:0]   listen_channel_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mnlc_pkg::BYTE_W-1:0]   in_byte_i,
  output logic                          push_o,
  output mnlc_pkg::packet_t             push_data_o,
  input  logic                          queue_full_i
);

  localparam int PosW = $clog2(PACKET_BYTES + 2);
  localparam logic [PosW-1:0] PosFull = PosW'(PACKET_BYTES);
  localparam logic [PosW-1:0] PosSat  = PosW'(PACKET_BYTES + 1);
  localparam logic [3:0] STATUS_NOTE_ON_CODE  = mnlc_pkg::STATUS_NOTE_ON;
  localparam logic [3:0] STATUS_NOTE_OFF_CODE = mnlc_pkg::STATUS_NOTE_OFF;

  logic                        valid_q, valid_d;
  logic [PosW-1:0]             pos_q, pos_d;
  logic [mnlc_pkg::BYTE_W-1:0] status_q, status_d;
  logic [mnlc_pkg::BYTE_W-1:0] note_q, note_d;
  logic [PosW-1:0]             pos_mid;
  logic                        start;
  logic                        accept;
  logic                        emit;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign start      = in_byte_i[7] && (in_byte_i[3:0] == listen_channel_i);

  always_comb begin
    valid_d = valid_q;
    pos_mid = pos_q;
    if (valid_q) begin
      if (start) begin
        // start byte anywhere but right after a complete packet breaks framing
        if (pos_q != PosFull) begin
          valid_d = 1'b0;
        end else begin
          pos_mid = '0;
        end
      end
    end else if (start) begin
      pos_mid = '0;
      valid_d = 1'b1;
    end

    status_d = (pos_mid == PosW'(0)) ? in_byte_i : status_q;
    note_d   = (pos_mid == PosW'(1)) ? in_byte_i : note_q;
    pos_d    = (pos_mid < PosSat) ? pos_mid + PosW'(1) : pos_mid;
    emit     = valid_d && (pos_d == PosFull);
  end

  always_comb begin
    push_data_o.note = note_d;
    case (status_d[7:4])
      STATUS_NOTE_ON_CODE:  push_data_o.kind = mnlc_pkg::KIND_NOTE_ON;
      STATUS_NOTE_OFF_CODE: push_data_o.kind = mnlc_pkg::KIND_NOTE_OFF;
      default:              push_data_o.kind = mnlc_pkg::KIND_OTHER;
    endcase
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      pos_q    <= '0;
      status_q <= '0;
      note_q   <= '0;
    end else if (accept) begin
      valid_q  <= valid_d;
      pos_q    <= pos_d;
      status_q <= status_d;
      note_q   <= note_d;
    end
  end

  // the position never runs past its saturation value
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosSat)
    else $error("framer position overran");

endmodule

/* rtl/core/mnlc_queue.sv */
// short packet queue between the framer and the light logic
`timescale 1ns / 1ps

module mnlc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mnlc_pkg::packet_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output mnlc_pkg::packet_t head_o
);

  localparam int Depth = mnlc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  mnlc_pkg::packet_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("pop from empty queue");

endmodule

/* rtl/core/mnlc_lights.sv */
// back end: note lookup, light state update and output register
`timescale 1ns / 1ps

module mnlc_lights #(
  parameter int LIGHT_COUNT = mnlc_pkg::DEFAULT_LIGHT_COUNT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mnlc_pkg::light_notes_t          light_notes_i,
  input  logic                            head_valid_i,
  input  mnlc_pkg::packet_t               head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mnlc_pkg::LIGHTS_W-1:0]   light_mask_o,
  output mnlc_pkg::kind_e                 kind_o,
  output logic                            found_o
);

  logic [mnlc_pkg::LIGHTS_W-1:0]    lights_q, lights_d;
  logic                             out_valid_q;
  logic [mnlc_pkg::LIGHTS_W-1:0]    mask_q;
  mnlc_pkg::kind_e                  kind_q;
  logic                             found_q;
  logic                             hit;
  logic [mnlc_pkg::LIGHT_IDX_W-1:0] hit_idx;
  logic [mnlc_pkg::LIGHTS_W-1:0]    hit_bit;
  logic                             found_d;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  // scan from the top so the lowest matching light wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = LIGHT_COUNT - 1; i >= 0; i--) begin
      if (head_i.note == {1'b0, light_notes_i[i]}) begin
        hit     = 1'b1;
        hit_idx = mnlc_pkg::LIGHT_IDX_W'(i);
      end
    end
    hit_bit = mnlc_pkg::LIGHTS_W'(1) << hit_idx;
  end

  always_comb begin
    lights_d = lights_q;
    found_d  = 1'b0;
    case (head_i.kind)
      mnlc_pkg::KIND_NOTE_ON: begin
        lights_d = lights_q | hit_bit;
        found_d  = hit;
      end
      mnlc_pkg::KIND_NOTE_OFF: begin
        lights_d = lights_q & ~hit_bit;
        found_d  = hit;
      end
      default: begin
        lights_d = lights_q;
        found_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lights_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        lights_q    <= lights_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mask_q  <= lights_d;
      kind_q  <= head_i.kind;
      found_q <= found_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign light_mask_o = mask_q;
  assign kind_o       = kind_q;
  assign found_o      = found_q;

  // a beat on the output always reflects the current light state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_o |-> mask_q == lights_q)
    else $error("output mask out of step with light state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == mnlc_pkg::KIND_OTHER |-> !found_q)
    else $error("found flag set on ignored message");

endmodule

/* rtl/core/midi_note_light_controller.sv */
// top level of the midi note light controller
//
//  port group      dir  beat contents
//  s_axis_*        in   one received midi byte
//  m_axis_*        out  light mask, message kind, note found
//  cfg_*           in   register write: listen channel, light notes 0..5
//
// one byte per cycle sustained while the queue has room; a completed packet
// is registered in the queue, then in the output reg on its way to m_axis.
// reset clears framing, light state and queue; notes return to 12..17.
// s_axis stalls whenever the two-entry packet queue is full, which happens
// only while m_axis is held off; every byte waits until an entry frees up.
`timescale 1ns / 1ps

module midi_note_light_controller #(
  parameter int PACKET_BYTES = mnlc_pkg::DEFAULT_PACKET_BYTES,
  parameter int LIGHT_COUNT  = mnlc_pkg::DEFAULT_LIGHT_COUNT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [5:0] light_mask, [7:6] zero
  output logic [2:0]                        m_axis_tuser,   // [1:0] message_kind, [2] note_found
  input  logic                              cfg_we_i,
  input  logic [mnlc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mnlc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [mnlc_pkg::CHAN_W-1:0]      listen_channel_q;
  mnlc_pkg::light_notes_t           light_notes_q;
  logic [mnlc_pkg::LIGHT_IDX_W-1:0] note_sel;

  logic                             push;
  mnlc_pkg::packet_t                push_data;
  logic                             queue_full;
  logic                             pop;
  logic                             head_valid;
  mnlc_pkg::packet_t                head;
  logic [mnlc_pkg::LIGHTS_W-1:0]    light_mask;
  mnlc_pkg::kind_e                  kind;
  logic                             found;

  assign note_sel = cfg_index_i - mnlc_pkg::CFG_LIGHT_NOTE_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_channel_q <= '0;
      for (int i = 0; i < mnlc_pkg::NUM_LIGHT_REGS; i++) begin
        light_notes_q[i] <= mnlc_pkg::light_note_reset(i);
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == mnlc_pkg::CFG_LISTEN_CHANNEL) begin
        listen_channel_q <= cfg_data_i[mnlc_pkg::CHAN_W-1:0];
      end else if (cfg_index_i inside
                   {[mnlc_pkg::CFG_LIGHT_NOTE_0:mnlc_pkg::CFG_LIGHT_NOTE_5]}) begin
        light_notes_q[note_sel] <= cfg_data_i[mnlc_pkg::NOTE_W-1:0];
      end
    end
  end

  mnlc_framer #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_framer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .listen_channel_i (listen_channel_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_byte_i        (s_axis_tdata),
    .push_o           (push),
    .push_data_o      (push_data),
    .queue_full_i     (queue_full)
  );

  mnlc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mnlc_lights #(
    .LIGHT_COUNT (LIGHT_COUNT)
  ) u_lights (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .light_notes_i (light_notes_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .light_mask_o  (light_mask),
    .kind_o        (kind),
    .found_o       (found)
  );

  assign m_axis_tdata = {2'b00, light_mask};
  assign m_axis_tuser = {found, kind};

endmodule

/* verif/midi_note_light_controller_tb.sv */
// testbench for the midi note light controller: directed and random midi byte streams
`timescale 1ns / 1ps

module midi_note_light_controller_tb;

  localparam int PKT_LEN = mnlc_pkg::DEFAULT_PACKET_BYTES;
  localparam int LIGHTS  = mnlc_pkg::DEFAULT_LIGHT_COUNT;

  localparam logic [mnlc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [3:0] STATUS_CTRL_CHANGE   = 4'hB;

  typedef struct packed {
    logic [mnlc_pkg::LIGHTS_W-1:0] mask;
    mnlc_pkg::kind_e               kind;
    logic                          found;
  } light_beat_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // [7:0] rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [5:0] light_mask, [7:6] zero
  logic [2:0]           m_axis_tuser;        // [1:0] message_kind, [2] note_found
  logic                 cfg_we_i      = 1'b0;
  logic [mnlc_pkg::CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [mnlc_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;

  // bench copy of the block state and registers
  logic [mnlc_pkg::CHAN_W-1:0]   listen_chan;
  logic [mnlc_pkg::NOTE_W-1:0]   note_map [mnlc_pkg::NUM_LIGHT_REGS];
  logic                          in_frame;
  logic [2:0]                    frame_pos;
  logic [7:0]                    frame_bytes [2];
  logic [mnlc_pkg::LIGHTS_W-1:0] lights_lit;

  light_beat_t pending_lights [$];
  int unsigned fail_count = 0;
  bit          gaps_on    = 1'b1;
  int          long_hold  = 0;

  midi_note_light_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // frames one byte and queues the light beat a finished packet produces
  function automatic void track_midi_byte(input logic [7:0] b);
    logic        start;
    int          hit;
    light_beat_t beat;
    start = b[7] && (b[3:0] == listen_chan);
    if (in_frame) begin
      if (start) begin
        if (frame_pos != PKT_LEN) in_frame = 1'b0;
        else frame_pos = '0;
      end
    end else if (start) begin
      frame_pos = '0;
      in_frame  = 1'b1;
    end
    if (frame_pos < 2) frame_bytes[frame_pos[0]] = b;
    if (frame_pos < PKT_LEN + 1) frame_pos = frame_pos + 3'd1;
    if (in_frame && frame_pos == PKT_LEN) begin
      hit = -1;
      // scan downward so the lowest matching light wins
      for (int i = LIGHTS - 1; i >= 0; i--) begin
        if ({1'b0, note_map[i]} == frame_bytes[1]) hit = i;
      end
      beat.found = (hit >= 0);
      if (hit < 0) hit = 0;
      case (frame_bytes[0][7:4])
        mnlc_pkg::STATUS_NOTE_ON: begin
          beat.kind       = mnlc_pkg::KIND_NOTE_ON;
          lights_lit[hit] = 1'b1;
        end
        mnlc_pkg::STATUS_NOTE_OFF: begin
          beat.kind       = mnlc_pkg::KIND_NOTE_OFF;
          lights_lit[hit] = 1'b0;
        end
        default: begin
          beat.kind  = mnlc_pkg::KIND_OTHER;
          beat.found = 1'b0;
        end
      endcase
      beat.mask = lights_lit;
      pending_lights.push_back(beat);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    track_midi_byte(b);
  endtask

  task automatic send_packet(input logic [7:0] status, input logic [7:0] note,
                             input logic [7:0] velocity);
    send_byte(status);
    send_byte(note);
    send_byte(velocity);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_lights.size() != 0) @(posedge clk_i);
    // bytes that finish no packet may still sit in the framer
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mnlc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mnlc_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == mnlc_pkg::CFG_LISTEN_CHANNEL) listen_chan = val[mnlc_pkg::CHAN_W-1:0];
    else if (idx >= mnlc_pkg::CFG_LIGHT_NOTE_0 && idx <= mnlc_pkg::CFG_LIGHT_NOTE_5)
      note_map[idx - mnlc_pkg::CFG_LIGHT_NOTE_0] = val;
  endtask

  // reset registers: channel 0, notes 12..17
  task automatic test_directed_packets();
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'd12, 8'h7F);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'd17, 8'h00);   // zero velocity is still note on
    send_packet({mnlc_pkg::STATUS_NOTE_OFF, 4'h0}, 8'd12, 8'h40);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'd127, 8'hFF);  // unmatched lands on light 0
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'h8F, 8'd0);    // other channel status as data
    send_packet({STATUS_CTRL_CHANGE, 4'h0}, 8'd13, 8'd1);
    // start byte inside a packet drops framing
    send_byte({mnlc_pkg::STATUS_NOTE_ON, 4'h0});
    send_byte({mnlc_pkg::STATUS_NOTE_ON, 4'h0});
    send_byte(8'd13);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'd13, 8'd1);
    // trailing bytes park the position, next start byte breaks framing
    send_byte(8'h45);
    send_byte(8'h7F);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'd14, 8'd9);
    send_packet({mnlc_pkg::STATUS_NOTE_OFF, 4'h0}, 8'd13, 8'd0);
  endtask

  task automatic test_register_extremes();
    write_reg(mnlc_pkg::CFG_LISTEN_CHANNEL, 7'h7F);   // upper bits dropped, channel 15
    write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0, 7'd0);
    write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0 + 3'd1, 7'd127);
    write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0 + 3'd2, 7'd127);
    write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0 + 3'd3, 7'd64);
    write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0 + 3'd4, 7'd0);
    write_reg(mnlc_pkg::CFG_LIGHT_NOTE_5, 7'd5);
    write_reg(CFG_UNUSED, 7'h55);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'hF}, 8'd127, 8'd100);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'hF}, 8'd0, 8'd100);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'hF}, 8'd64, 8'd1);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'hF}, 8'd5, 8'd1);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'd64, 8'd1);    // wrong channel
    send_packet({mnlc_pkg::STATUS_NOTE_OFF, 4'hF}, 8'd127, 8'd0);
    send_packet({mnlc_pkg::STATUS_NOTE_OFF, 4'hF}, 8'd200, 8'd0);
    send_packet(8'hFF, 8'd5, 8'd0);
    wait_quiet();
    write_reg(mnlc_pkg::CFG_LISTEN_CHANNEL, 7'd0);
    send_packet({mnlc_pkg::STATUS_NOTE_OFF, 4'h0}, 8'd64, 8'd3);
    send_packet({mnlc_pkg::STATUS_NOTE_ON, 4'h0}, 8'd5, 8'd3);
  endtask

  task automatic test_output_backpressure();
    gaps_on   = 1'b0;
    long_hold = 80;
    for (int i = 0; i < 10; i++) begin
      send_packet({(i % 2 == 0) ? mnlc_pkg::STATUS_NOTE_ON : mnlc_pkg::STATUS_NOTE_OFF,
                   listen_chan},
                  {1'b0, note_map[i % LIGHTS]}, 8'd64);
    end
    wait_quiet();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          sent;
    int          pick;
    logic [3:0]  nib;
    logic [7:0]  note;
    for (int phase = 0; phase < 7; phase++) begin
      wait_quiet();
      gaps_on = (phase < 6) && (phase != 3);
      case (phase)
        1:       write_reg(mnlc_pkg::CFG_LISTEN_CHANNEL, 7'd15);
        2:       write_reg(mnlc_pkg::CFG_LISTEN_CHANNEL, 7'd0);
        default: write_reg(mnlc_pkg::CFG_LISTEN_CHANNEL, 7'($urandom_range(0, 127)));
      endcase
      for (int n = 0; n < mnlc_pkg::NUM_LIGHT_REGS; n++) begin
        if (phase == 4)
          write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0 + 3'(n), (n % 2 == 0) ? 7'd0 : 7'd127);
        else if ($urandom_range(0, 3) == 0)
          write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0 + 3'(n), 7'($urandom_range(0, 127)));
        else write_reg(mnlc_pkg::CFG_LIGHT_NOTE_0 + 3'(n), 7'($urandom_range(60, 67)));
      end
      if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED, 7'($urandom_range(0, 127)));
      sent = 0;
      while (sent < 200) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: nib = mnlc_pkg::STATUS_NOTE_ON;
          4, 5, 6:    nib = mnlc_pkg::STATUS_NOTE_OFF;
          default:    nib = 4'($urandom_range(4'hA, 4'hF));
        endcase
        if ($urandom_range(0, 9) < 7) note = {1'b0, note_map[$urandom_range(0, LIGHTS - 1)]};
        else note = 8'($urandom_range(0, 255));
        if (pick < 82) begin
          send_packet({nib, listen_chan}, note, 8'($urandom_range(0, 255)));
          sent += 3;
        end else if (pick < 90) begin
          // cut short, the next status byte lands mid-packet
          send_byte({nib, listen_chan});
          if ($urandom_range(0, 1) == 0) send_byte(note);
          sent += 2;
        end else if (pick < 95) begin
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_packet({nib, listen_chan}, note, 8'($urandom_range(0, 127)));
          send_byte(8'($urandom_range(0, 127)));
          sent += 4;
        end
      end
    end
  endtask

  // sink side: short random stalls, or one long hold when asked
  initial begin : light_sink
    int n;
    forever begin
      @(posedge clk_i);
      if (long_hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (long_hold) @(posedge clk_i);
        long_hold = 0;
        m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : light_check
    light_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_lights.size() == 0) begin
        $error("unexpected output beat: light_mask %0h", m_axis_tdata[5:0]);
        fail_count++;
      end else begin
        want = pending_lights.pop_front();
        if (m_axis_tdata[5:0] !== want.mask) begin
          $error("light_mask mismatch: expected %0h, actual %0h", want.mask, m_axis_tdata[5:0]);
          fail_count++;
        end
        if (m_axis_tuser[1:0] !== want.kind) begin
          $error("message_kind mismatch: expected %0d, actual %0d", want.kind,
                 m_axis_tuser[1:0]);
          fail_count++;
        end
        if (m_axis_tuser[2] !== want.found) begin
          $error("note_found mismatch: expected %0b, actual %0b", want.found, m_axis_tuser[2]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    listen_chan = '0;
    for (int i = 0; i < mnlc_pkg::NUM_LIGHT_REGS; i++) begin
      note_map[i] = mnlc_pkg::NOTE_W'(12 + i);
    end
    in_frame       = 1'b0;
    frame_pos      = '0;
    frame_bytes[0] = '0;
    frame_bytes[1] = '0;
    lights_lit     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_packets();
    wait_quiet();
    test_register_extremes();
    wait_quiet();
    test_output_backpressure();
    test_random_traffic();
    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
